// ----- rtl/core/mics_pkg.sv -----
// Shared types, constants and the build-time coefficient table for the Moyal sampler.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package mics_pkg;

    localparam int MAX_TERMS       = 32;
    localparam int COEFF_FRAC_BITS = 32;
    localparam int TERM_W          = 6;

    localparam logic [31:0] HALF_ROOT_PI_Q32 = 32'd3806315662;
    localparam logic [31:0] LN2_Q32          = 32'd2977044472;

    typedef enum logic [1:0] {
        REG_LOCATION = 2'd0,
        REG_SCALE    = 2'd1,
        REG_TERMS    = 2'd2
    } cfg_reg_t;

    typedef logic [63:0] coeff_rom_t [MAX_TERMS];

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add64 = s[64] ? {64{1'b1}} : s[63:0];
        end
    endfunction

    // (a*b) >> COEFF_FRAC_BITS, saturating at 2^64-1
    function automatic logic [63:0] mul_shift_f(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        logic [127:0] q;
        begin
            p = {64'b0, a} * {64'b0, b};
            q = p >> COEFF_FRAC_BITS;
            mul_shift_f = (q[127:64] != 64'b0) ? {64{1'b1}} : q[63:0];
        end
    endfunction

    // restoring divide, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        begin
            rem = 65'b0;
            quo = 64'b0;
            for (int i = 63; i >= 0; i--)
            begin
                rem = {rem[63:0], num[i]};
                if (rem >= {1'b0, den})
                begin
                    rem    = rem - {1'b0, den};
                    quo[i] = 1'b1;
                end
            end
            udiv64 = quo;
        end
    endfunction

    // inverse-erf series: c_k from the recursion, stored as c_k/(2k+1)
    function automatic coeff_rom_t build_rom();
        logic [63:0] c [MAX_TERMS];
        coeff_rom_t  r;
        logic [63:0] acc;
        logic [63:0] den;
        begin
            c[0] = 64'd1 << COEFF_FRAC_BITS;
            for (int k = 1; k < MAX_TERMS; k++)
            begin
                acc = 64'b0;
                for (int m = 0; m < k; m++)
                begin
                    den = 64'((m + 1) * (2 * m + 1));
                    acc = sat_add64(acc, udiv64(mul_shift_f(c[m], c[k - 1 - m]), den));
                end
                c[k] = acc;
            end
            for (int k = 0; k < MAX_TERMS; k++)
            begin
                r[k] = udiv64(c[k], 64'(2 * k + 1));
            end
            build_rom = r;
        end
    endfunction

    localparam coeff_rom_t COEFF_ROM = build_rom();

endpackage

// ----- rtl/core/mics_front.sv -----
// Front end: t = (sqrt(pi)/2)(1-u) and t^2, two register stages.
// Uses mics_pkg.
module mics_front (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] in_u,
    output logic        out_valid,
    output logic [31:0] out_p,
    output logic [31:0] out_t2
);

    logic        v1_reg, v2_reg;
    logic [31:0] t_reg, t_next;
    logic [31:0] p_reg, t2_reg;
    logic [63:0] prod1, prod2;

    // 1-u fits 32 bits except for u == 0, where t is the constant itself
    assign prod1  = {32'b0, mics_pkg::HALF_ROOT_PI_Q32} * {32'b0, 32'(32'd0 - in_u)};
    assign t_next = (in_u == 32'd0) ? mics_pkg::HALF_ROOT_PI_Q32 : prod1[63:32];
    assign prod2  = {32'b0, t_reg} * {32'b0, t_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg  <= t_next;
            p_reg  <= t_reg;
            t2_reg <= prod2[63:32];
        end
    end

    assign out_valid = v2_reg;
    assign out_p     = p_reg;
    assign out_t2    = t2_reg;

endmodule

// ----- rtl/core/mics_term.sv -----
// One series stage: adds the previous term into y, forms term K and the next odd power.
// Uses mics_pkg (coefficient table, saturating add).
module mics_term #(
    parameter int K = 0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [5:0]  n_eff,
    input  logic        in_valid,
    input  logic [31:0] in_p,
    input  logic [31:0] in_t2,
    input  logic [63:0] in_y,
    input  logic [63:0] in_term,
    output logic        out_valid,
    output logic [31:0] out_p,
    output logic [31:0] out_t2,
    output logic [63:0] out_y,
    output logic [63:0] out_term
);

    localparam logic [63:0] COEFF = mics_pkg::COEFF_ROM[K];
    localparam logic [31:0] C_HI  = COEFF[63:32];
    localparam logic [31:0] C_LO  = COEFF[31:0];

    logic        v_reg;
    logic [31:0] p_reg, t2_reg;
    logic [63:0] y_reg, term_reg;
    logic [63:0] prod_hi, prod_lo, prod_p, term_next;
    logic        active;

    assign active    = n_eff > 6'(K);
    assign prod_hi   = {32'b0, C_HI} * {32'b0, in_p};
    assign prod_lo   = {32'b0, C_LO} * {32'b0, in_p};
    assign prod_p    = {32'b0, in_p} * {32'b0, in_t2};
    assign term_next = active ? (prod_hi + {32'b0, prod_lo[63:32]}) : 64'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= prod_p[63:32];
            t2_reg   <= in_t2;
            y_reg    <= mics_pkg::sat_add64(in_y, in_term);
            term_reg <= term_next;
        end
    end

    assign out_valid = v_reg;
    assign out_p     = p_reg;
    assign out_t2    = t2_reg;
    assign out_y     = y_reg;
    assign out_term  = term_reg;

endmodule

// ----- rtl/core/mics_log.sv -----
// log2 of the series sum: final add, msb search, normalize, 32 squaring stages.
// Uses mics_pkg (saturating add).
module mics_log (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] in_y,
    input  logic [63:0] in_term,
    output logic        out_valid,
    output logic [5:0]  out_e,
    output logic [31:0] out_frac,
    output logic        out_zero
);

    localparam int SQ = 32;

    // final sum
    logic        va_reg;
    logic [63:0] ya_reg;
    // msb search, per 16-bit group
    logic        vb_reg;
    logic [63:0] yb_reg;
    logic [3:0]  nz_reg, nz_next;
    logic [3:0]  pos_reg [4];
    logic [3:0]  pos_next [4];
    // exponent
    logic        vc_reg;
    logic [63:0] yc_reg;
    logic [5:0]  ec_reg, e_next;
    logic        zc_reg;
    // squaring chain, index 0 is the normalized mantissa
    logic        vs_reg [SQ+1];
    logic [31:0] m_reg  [SQ+1];
    logic [31:0] fr_reg [SQ+1];
    logic [5:0]  es_reg [SQ+1];
    logic        zs_reg [SQ+1];
    logic [63:0] shifted;

    always_comb
    begin
        for (int g = 0; g < 4; g++)
        begin
            nz_next[g]  = |ya_reg[16*g +: 16];
            pos_next[g] = 4'd0;
            for (int b = 0; b < 16; b++)
            begin
                if (ya_reg[16*g + b])
                begin
                    pos_next[g] = 4'(b);
                end
            end
        end
    end

    always_comb
    begin
        e_next = 6'd0;
        for (int g = 0; g < 4; g++)
        begin
            if (nz_reg[g])
            begin
                e_next = {2'(g), pos_reg[g]};
            end
        end
    end

    assign shifted = (ec_reg >= 6'd31) ? (yc_reg >> (ec_reg - 6'd31))
                                       : (yc_reg << (6'd31 - ec_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            vc_reg    <= 1'b0;
            vs_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            va_reg    <= in_valid;
            vb_reg    <= va_reg;
            vc_reg    <= vb_reg;
            vs_reg[0] <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ya_reg    <= mics_pkg::sat_add64(in_y, in_term);
            yb_reg    <= ya_reg;
            nz_reg    <= nz_next;
            pos_reg   <= pos_next;
            yc_reg    <= yb_reg;
            ec_reg    <= e_next;
            zc_reg    <= (nz_reg == 4'b0);
            m_reg[0]  <= shifted[31:0];
            fr_reg[0] <= 32'b0;
            es_reg[0] <= ec_reg;
            zs_reg[0] <= zc_reg;
        end
    end

    // each stage squares the Q1.31 mantissa and yields one fraction bit
    for (genvar i = 1; i <= SQ; i++)
    begin : g_sq
        logic [63:0] sq;
        logic        hi;
        logic [31:0] m_next;
        logic [31:0] fr_next;

        assign sq     = {32'b0, m_reg[i-1]} * {32'b0, m_reg[i-1]};
        assign hi     = sq[63];
        assign m_next = hi ? sq[63:32] : sq[62:31];

        always_comb
        begin
            fr_next          = fr_reg[i-1];
            fr_next[SQ - i]  = hi;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vs_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vs_reg[i] <= vs_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[i]  <= m_next;
                fr_reg[i] <= fr_next;
                es_reg[i] <= es_reg[i-1];
                zs_reg[i] <= zs_reg[i-1];
            end
        end
    end

    assign out_valid = vs_reg[SQ];
    assign out_e     = es_reg[SQ];
    assign out_frac  = fr_reg[SQ];
    assign out_zero  = zs_reg[SQ];

endmodule

// ----- rtl/core/mics_out.sv -----
// Back end: ln from log2, times 2*sigma, subtracted from the location, saturated.
// Uses mics_pkg (ln 2 constant); the last stage is the output register.
module mics_out (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [31:0] location,
    input  logic [30:0] scale,
    input  logic        in_valid,
    input  logic [5:0]  in_e,
    input  logic [31:0] in_frac,
    input  logic        in_zero,
    output logic        out_valid,
    output logic [31:0] out_variate,
    output logic        out_clipped
);

    localparam logic signed [39:0] F_OFFS = 40'sh20_0000_0000;
    localparam logic signed [39:0] HALF   = 40'sh00_8000_0000;

    logic [5:0]  v_reg;
    logic [5:0]  neg_reg;
    logic [5:0]  zero_reg;

    logic signed [39:0] lg;
    logic [39:0] lg_abs;
    logic [37:0] lmag_reg;
    logic [63:0] plo_reg, plo_next;
    logic [37:0] phi_reg, phi_next;
    logic [38:0] ln_sum;
    logic [37:0] ln_reg;
    logic [62:0] qlo_reg, qlo_next;
    logic [36:0] qhi_reg, qhi_next;
    logic [38:0] d_reg;
    logic signed [41:0] x;
    logic [31:0] var_reg, var_next;
    logic        clip_reg, clip_next;

    assign lg     = $signed({2'b0, in_e, in_frac}) - F_OFFS + HALF;
    assign lg_abs = lg[39] ? 40'(-lg) : 40'(lg);

    assign plo_next = {32'b0, lmag_reg[31:0]} * {32'b0, mics_pkg::LN2_Q32};
    assign phi_next = {32'b0, lmag_reg[37:32]} * {6'b0, mics_pkg::LN2_Q32};
    assign ln_sum   = {1'b0, phi_reg} + {7'b0, plo_reg[63:32]};
    assign qlo_next = {31'b0, ln_reg[31:0]} * {32'b0, scale};
    assign qhi_next = {31'b0, ln_reg[37:32]} * {6'b0, scale};

    assign x = neg_reg[4] ? ($signed({{10{location[31]}}, location}) + $signed({3'b0, d_reg}))
                          : ($signed({{10{location[31]}}, location}) - $signed({3'b0, d_reg}));

    always_comb
    begin
        if (zero_reg[4])
        begin
            var_next  = 32'h7FFF_FFFF;
            clip_next = 1'b1;
        end
        else if (x > 42'sh0_7FFF_FFFF)
        begin
            var_next  = 32'h7FFF_FFFF;
            clip_next = 1'b1;
        end
        else if (x < -42'sh0_8000_0000)
        begin
            var_next  = 32'h8000_0000;
            clip_next = 1'b1;
        end
        else
        begin
            var_next  = x[31:0];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 6'b0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg  <= {neg_reg[4:0], lg[39]};
            zero_reg <= {zero_reg[4:0], in_zero};
            lmag_reg <= lg_abs[37:0];
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            ln_reg   <= ln_sum[37:0];
            qlo_reg  <= qlo_next;
            qhi_reg  <= qhi_next;
            d_reg    <= {1'b0, qhi_reg, 1'b0} + {7'b0, qlo_reg[62:31]};
            var_reg  <= var_next;
            clip_reg <= clip_next;
        end
    end

    assign out_valid   = v_reg[5];
    assign out_variate = var_reg;
    assign out_clipped = clip_reg;

endmodule

// ----- rtl/core/moyal_inverse_cdf_sampler.sv -----
// Top level of the Moyal variate generator: config registers, pipeline control, assertions.
// Uses mics_pkg, mics_front, mics_term, mics_log, mics_out.
//
// One uniform fraction u (Q0.32) per beat becomes one Moyal sample x (signed Q16.16):
// t = (sqrt(pi)/2)(1-u), y = sum of the first series_terms terms of the inverse-erf
// series, x = location - 2*scale*ln(sqrt(2)*y). The block takes one beat per clock
// while the output is not stalled and returns one beat per input, in order, through
// 2 front stages, one stage per series term (32, fixed, unused terms add zero),
// 36 stages for the final sum and log2 (one squaring multiplier per fraction bit)
// and 6 back-end stages. The whole pipe advances when the output register is empty
// or being read, so a stall at the output holds every stage. clipped (tuser) is 1 when x
// hit a rail or when y summed to zero (u at or next to 1), in which case x = 0x7FFFFFFF.
// Config writes are always taken; write only while no beat is in flight.
// series_terms of 0 acts as 1, above 32 acts as 32; index 3 is ignored.
module moyal_inverse_cdf_sampler (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] uniform_sample
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] variate
    output logic [0:0]  m_tuser,   // [0] clipped
    // config writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NT = mics_pkg::MAX_TERMS;

    logic [31:0] location_reg;
    logic [30:0] scale_reg;
    logic [5:0]  terms_reg;
    logic [5:0]  n_eff;
    logic        en;

    // chain between front end, term stages and log unit
    logic        tv   [NT+1];
    logic [31:0] tp   [NT+1];
    logic [31:0] tt2  [NT+1];
    logic [63:0] ty   [NT+1];
    logic [63:0] tterm[NT+1];

    logic        lv;
    logic [5:0]  le;
    logic [31:0] lfrac;
    logic        lzero;

    assign cfg_ready = 1'b1;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;

    assign n_eff = (terms_reg == 6'd0) ? 6'd1 :
                   (terms_reg > 6'(NT)) ? 6'(NT) : terms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            location_reg <= 32'd0;
            scale_reg    <= 31'd65536;
            terms_reg    <= 6'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mics_pkg::REG_LOCATION: location_reg <= cfg_data;
                mics_pkg::REG_SCALE:    scale_reg    <= cfg_data[30:0];
                mics_pkg::REG_TERMS:    terms_reg    <= cfg_data[5:0];
                default:                ;
            endcase
        end
    end

    mics_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_u      (s_tdata),
        .out_valid (tv[0]),
        .out_p     (tp[0]),
        .out_t2    (tt2[0])
    );

    assign ty[0]    = 64'b0;
    assign tterm[0] = 64'b0;

    for (genvar k = 0; k < NT; k++)
    begin : g_term
        mics_term #(.K(k)) u_term (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .n_eff     (n_eff),
            .in_valid  (tv[k]),
            .in_p      (tp[k]),
            .in_t2     (tt2[k]),
            .in_y      (ty[k]),
            .in_term   (tterm[k]),
            .out_valid (tv[k+1]),
            .out_p     (tp[k+1]),
            .out_t2    (tt2[k+1]),
            .out_y     (ty[k+1]),
            .out_term  (tterm[k+1])
        );
    end

    mics_log u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tv[NT]),
        .in_y      (ty[NT]),
        .in_term   (tterm[NT]),
        .out_valid (lv),
        .out_e     (le),
        .out_frac  (lfrac),
        .out_zero  (lzero)
    );

    mics_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .location    (location_reg),
        .scale       (scale_reg),
        .in_valid    (lv),
        .in_e        (le),
        .in_frac     (lfrac),
        .in_zero     (lzero),
        .out_valid   (m_tvalid),
        .out_variate (m_tdata),
        .out_clipped (m_tuser[0])
    );

`ifndef SYNTHESIS
    // a clipped sample always sits on one of the two rails
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000))
        else $error("clipped sample not on a rail");

    // effective term count stays within the table
    a_terms: assert property (@(posedge clk) disable iff (!rst_n)
        n_eff >= 6'd1 && n_eff <= 6'(NT))
        else $error("term count out of range");

    // a stalled output freezes the whole pipe, including the input side
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");
`endif

endmodule

// ----- dv/moyal_sampler_checker.sv -----
// Scoreboard for the Moyal sampler: watches the config, input and output streams.
// Predicts each sample from its own copy of the registers and coefficient table.
// Depends on mics_pkg for the register index names and constants.
module moyal_sampler_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          outstanding
);

    typedef struct packed {
        logic [31:0] variate;
        logic        clipped;
    } sample_t;

    sample_t           samples_due[$];
    logic [63:0]       coeff[mics_pkg::MAX_TERMS];
    logic signed [63:0] mu;
    logic [30:0]       sigma;
    logic [5:0]        n_terms;

    function automatic logic [63:0] mulsh(input logic [63:0] a, input logic [63:0] b,
                                          input int s);
        logic [127:0] q;
        begin
            q = ({64'b0, a} * {64'b0, b}) >> s;
            return (q[127:64] != 0) ? {64{1'b1}} : q[63:0];
        end
    endfunction

    function automatic logic [63:0] addsat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? {64{1'b1}} : s[63:0];
        end
    endfunction

    // log2 of v (v > 0) in signed Q.32
    function automatic logic signed [63:0] log2_fix(input logic [63:0] v);
        int          e;
        logic [63:0] m;
        logic [63:0] frac;
        begin
            e = 63;
            frac = 0;
            while (e > 0 && !v[e])
                e--;
            m = (e >= 31) ? (v >> (e - 31)) : (v << (31 - e));
            for (int i = 1; i <= 32; i++)
            begin
                m = (m * m) >> 31;
                if (m >= 64'h1_0000_0000)
                begin
                    m = m >> 1;
                    frac[32 - i] = 1'b1;
                end
            end
            return ($signed(64'(e)) <<< 32) + $signed(frac);
        end
    endfunction

    function automatic sample_t predict_sample(input logic [31:0] u);
        logic [63:0]        t, t2, p, y, lmag, dmag;
        logic signed [63:0] lg, x;
        int                 n;
        sample_t            r;
        begin
            t  = mulsh(64'(mics_pkg::HALF_ROOT_PI_Q32), 64'h1_0000_0000 - 64'(u), 32);
            t2 = mulsh(t, t, 32);
            p  = t;
            y  = 0;
            n  = (n_terms == 0) ? 1 :
                 (n_terms > mics_pkg::MAX_TERMS) ? mics_pkg::MAX_TERMS : n_terms;
            for (int k = 0; k < n; k++)
            begin
                y = addsat(y, mulsh(coeff[k], p, 32));
                p = mulsh(p, t2, 32);
            end
            if (y == 0)
                return '{32'h7FFF_FFFF, 1'b1};
            lg   = log2_fix(y) - (64'sd32 <<< 32) + 64'sd2147483648;
            lmag = (lg < 0) ? -lg : lg;
            lmag = mulsh(lmag, 64'(mics_pkg::LN2_Q32), 32);
            dmag = mulsh(64'(sigma), lmag, 31);
            x    = (lg < 0) ? mu + $signed(dmag) : mu - $signed(dmag);
            if (x > 64'sd2147483647)
                r = '{32'h7FFF_FFFF, 1'b1};
            else if (x < -64'sd2147483648)
                r = '{32'h8000_0000, 1'b1};
            else
                r = '{x[31:0], 1'b0};
            return r;
        end
    endfunction

    // coefficient table from the series recursion, c_k/(2k+1)
    initial
    begin
        logic [63:0] c[mics_pkg::MAX_TERMS];
        logic [63:0] acc;
        c[0] = 64'd1 << mics_pkg::COEFF_FRAC_BITS;
        for (int k = 1; k < mics_pkg::MAX_TERMS; k++)
        begin
            acc = 0;
            for (int m = 0; m < k; m++)
                acc = addsat(acc, mulsh(c[m], c[k - 1 - m], mics_pkg::COEFF_FRAC_BITS)
                                  / 64'((m + 1) * (2 * m + 1)));
            c[k] = acc;
        end
        for (int k = 0; k < mics_pkg::MAX_TERMS; k++)
            coeff[k] = c[k] / 64'(2 * k + 1);
    end

    assign outstanding = samples_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        sample_t want;
        if (!rst_n)
        begin
            mu      <= 0;
            sigma   <= 31'd65536;
            n_terms <= 6'd16;
            errors  <= 0;
            samples_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mics_pkg::REG_LOCATION: mu      <= $signed(cfg_data);
                    mics_pkg::REG_SCALE:    sigma   <= cfg_data[30:0];
                    mics_pkg::REG_TERMS:    n_terms <= cfg_data[5:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                samples_due = {samples_due, predict_sample(s_tdata)};
            if (m_tvalid && m_tready)
            begin
                if (samples_due.size() == 0)
                begin
                    $error("unexpected output beat: variate %h clipped %0d",
                           m_tdata, m_tuser[0]);
                    errors <= errors + 1;
                end
                else
                begin
                    want = samples_due.pop_front();
                    if (want.variate !== m_tdata)
                    begin
                        $error("variate: expected %h, got %h", want.variate, m_tdata);
                        errors <= errors + 1;
                    end
                    else if (want.clipped !== m_tuser[0])
                    begin
                        $error("clipped: expected %0d, got %0d", want.clipped, m_tuser[0]);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- dv/tb_moyal_inverse_cdf_sampler.sv -----
// Testbench top for the Moyal sampler: clock, reset, config writes, stimulus, verdict.
// Depends on mics_pkg, moyal_inverse_cdf_sampler and moyal_sampler_checker.
module tb_moyal_inverse_cdf_sampler;

    localparam logic [1:0] REG_UNUSED = 2'd3;   // past the register list
    localparam int PIPE_CYCLES = 100;
    localparam int IDLE_LIMIT  = 5000;          // cycles with no beat anywhere

    // directed fractions: extremes, and the zero-sum corner near u = 1
    localparam logic [31:0] CORNER_U [9] = '{32'h0, 32'h1, 32'h8000_0000, 32'hFFFF_FFFF,
                                             32'hFFFF_FFFE, 32'hFFFF_FF00, 32'h5555_5555,
                                             32'hAAAA_AAAA, 32'h0000_FFFF};
    localparam logic [31:0] ONE_TERM_U [3] = '{32'h0, 32'h4000_0000, 32'hFFFF_FFF0};
    localparam logic [31:0] RAIL_U [4] = '{32'h0, 32'h1000, 32'hFFFF_F000, 32'hC000_0000};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] uniform_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [31:0] variate
    logic [0:0]  m_tuser;    // [0] clipped
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    int errors;
    int outstanding;
    int send_idle_pct;    // chance per cycle that the source holds back
    int recv_stall_pct;   // chance per cycle that the sink stalls
    bit long_hold;        // sink held off for a long stretch
    int quiet_cycles;

    moyal_inverse_cdf_sampler dut (.*);

    moyal_sampler_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // sink side: random stalls, or a long hold-off while the source keeps pushing
    always @(posedge clk)
        m_tready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);

    // watchdog: any accepted beat resets the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("moyal_inverse_cdf_sampler regression: fail");
            $finish;
        end
    end

    // called at a rising edge; returns after the beat is taken
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [31:0] u);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= u;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // let every beat in flight drain before touching the registers
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    // mix of full-range fractions, values near 0 (t large) and near 1 (y tiny or zero)
    function automatic logic [31:0] random_fraction();
        case ($urandom_range(3))
            0: return $urandom() >> $urandom_range(31);
            1: return ~($urandom() >> $urandom_range(31));
            default: return $urandom();
        endcase
    endfunction

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++)
            send_sample(random_fraction());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = mics_pkg::REG_LOCATION;
        cfg_data       = '0;
        long_hold      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, field extremes, zero-sum corner near u = 1
        for (int i = 0; i < 9; i++)
            send_sample(CORNER_U[i]);
        drain();

        // term count 0 acts as one term, index past the list is dropped
        write_reg(mics_pkg::REG_TERMS, 32'd0);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        for (int i = 0; i < 3; i++)
            send_sample(ONE_TERM_U[i]);
        drain();

        // rails: huge scale pushes x past both limits
        write_reg(mics_pkg::REG_TERMS, 32'd63);
        write_reg(mics_pkg::REG_SCALE, 32'hFFFF_FFFF);
        write_reg(mics_pkg::REG_LOCATION, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_sample(RAIL_U[i]);
        drain();
        write_reg(mics_pkg::REG_LOCATION, 32'h8000_0000);
        for (int i = 0; i < 4; i++)
            send_sample(RAIL_U[i]);
        drain();

        // random phases over several settings and handshake mixes
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            case (ph)
                0: write_reg(mics_pkg::REG_TERMS, 32'd32);
                1: write_reg(mics_pkg::REG_TERMS, 32'd1);
                2: write_reg(mics_pkg::REG_TERMS, 32'd33);
                default: write_reg(mics_pkg::REG_TERMS, $urandom_range(63));
            endcase
            write_reg(mics_pkg::REG_SCALE, (ph == 0) ? 32'd0 :
                                 (ph == 1) ? 32'h7FFF_FFFF : $urandom_range(32'h0004_0000));
            write_reg(mics_pkg::REG_LOCATION, (ph == 2) ? 32'h8000_0000 :
                                    (ph == 3) ? 32'h7FFF_FFFF : $urandom());
            if (ph == 4)
            begin
                // long sink hold-off so the pipe fills and backs up the input
                fork
                    begin
                        long_hold = 1'b1;
                        repeat (400) @(posedge clk);
                        long_hold = 1'b0;
                    end
                    random_run(105);
                join
            end
            else
                random_run(105);
            drain();
        end

        while (outstanding != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("moyal_inverse_cdf_sampler regression: pass");
        else
            $display("moyal_inverse_cdf_sampler regression: fail");
        $finish;
    end

endmodule
